// ===== rtl/rilsbe_pkg.sv =====
package rilsbe_pkg;

  localparam int XLEN   = 32;
  localparam int GPR_AW = 5;
  localparam int GPR_N  = 32;
  localparam int PA_W   = 31;
  localparam int IMM_W  = 12;
  localparam int OFFS_W = 14;
  localparam int OP_W   = 4;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ORI   = 4'd0;
  localparam op_t OP_ANDI  = 4'd1;
  localparam op_t OP_XORI  = 4'd2;
  localparam op_t OP_ADDIW = 4'd3;
  localparam op_t OP_SLTUI = 4'd4;
  localparam op_t OP_LDW   = 4'd5;
  localparam op_t OP_STW   = 4'd6;
  localparam op_t OP_LDB   = 4'd7;
  localparam op_t OP_STB   = 4'd8;
  localparam op_t OP_BEQ   = 4'd9;
  localparam op_t OP_BNE   = 4'd10;
  localparam op_t OP_BGEU  = 4'd11;

  // register file write port
  typedef struct packed {
    logic              vld;
    logic [GPR_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } gpr_wr_t;

  // execute stage result handed to the memory/writeback stage
  typedef struct packed {
    logic              wr;       // register write, rd already known nonzero
    logic [GPR_AW-1:0] rd;
    logic [XLEN-1:0]   alu_val;
    logic              is_mem;
    logic              ld_w;
    logic              ld_b;
    logic              st_w;
    logic              st_b;
    logic              fault;
    logic              taken;
    logic [PA_W-1:0]   paddr;
    logic [XLEN-1:0]   st_data;
    logic [OFFS_W-1:0] offs;
  } ex_t;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              reg_written;
    logic [GPR_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              mem_written;
    logic [PA_W-1:0]   access_addr;
    logic              branch_taken;
    logic              align_fault;
  } res_t;

  function automatic logic [XLEN-1:0] sext12(input logic [IMM_W-1:0] v);
    return {{(XLEN-IMM_W){v[IMM_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/rilsbe_if.sv =====
interface rilsbe_in_if;
  logic                   valid;
  logic                   ready;
  rilsbe_pkg::op_t        operation;
  logic [31:0]            instr_word;

  modport source (output valid, operation, instr_word, input ready);
  modport sink   (input valid, operation, instr_word, output ready);
endinterface

interface rilsbe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic        mem_written;
  logic [30:0] access_addr;
  logic        branch_taken;
  logic        align_fault;

  modport source (output valid, next_pc, reg_written, dest_reg, dest_value, mem_written,
                  access_addr, branch_taken, align_fault, input ready);
  modport sink   (input valid, next_pc, reg_written, dest_reg, dest_value, mem_written,
                  access_addr, branch_taken, align_fault, output ready);
endinterface

// ===== rtl/risc_imm_load_store_branch_execute_core.sv =====
// channel | dir | handshake           | payload
// in_ch   | in  | valid/ready         | operation(4), instr_word(32)
// out_ch  | out | valid/ready         | next_pc, reg_written, dest_reg, dest_value,
//         |     |                     | mem_written, access_addr, branch_taken, align_fault
//
// One item per cycle sustained while results are taken; a result passes through
// the input register, the execute register and then the output register.
// Register and memory hazards are resolved by bypass, so back-to-back dependent
// items never wait. After reset the data memory is swept to zero, one word per
// cycle; in_ch.ready stays low during the sweep.
// A result held in the output register and not taken stalls the whole pipe.
// MEM_WORDS must be a power of two; the word index is a bit slice of the address.
module risc_imm_load_store_branch_execute_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  rilsbe_in_if.sink          in_ch,
  rilsbe_out_if.source       out_ch
);
  import rilsbe_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic            adv, clr_busy;
  // input register
  logic            x_vld_r;
  op_t             x_op_r;
  logic [XLEN-1:0] x_iw_r;
  logic [XLEN-1:0] gpr_a, gpr_b, a_fwd, d_fwd;
  ex_t             ex_x;
  // memory / writeback stage
  logic            y_vld_r;
  ex_t             ex_r;
  logic [XLEN-1:0] mem_word, ld_byte_ext, st_mask, st_word_b, st_word;
  logic [4:0]      byte_sh;
  logic [7:0]      ld_byte;
  logic            y_mem_we;
  gpr_wr_t         y_wr;
  logic [XLEN-1:0] pc_r, npc, br_tgt;
  // output register
  logic            out_vld_r;
  res_t            res_r, res_nxt;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && !clr_busy;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_op_r <= in_ch.operation;
      x_iw_r <= in_ch.instr_word;
      ex_r   <= ex_x;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r   <= 1'b0;
      y_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
    end else if (adv) begin
      x_vld_r   <= in_ch.valid && !clr_busy;
      y_vld_r   <= x_vld_r;
      out_vld_r <= y_vld_r;
      if (y_vld_r) begin
        pc_r <= npc;
      end
    end
  end

  rilsbe_gpr u_gpr (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .rd_idx_a (in_ch.instr_word[9:5]),
    .rd_idx_b (in_ch.instr_word[4:0]),
    .wr       (y_wr),
    .rdata_a  (gpr_a),
    .rdata_b  (gpr_b)
  );

  // the item one ahead has not written back yet
  assign a_fwd = (y_wr.vld && (y_wr.idx == x_iw_r[9:5])) ? y_wr.data : gpr_a;
  assign d_fwd = (y_wr.vld && (y_wr.idx == x_iw_r[4:0])) ? y_wr.data : gpr_b;

  rilsbe_alu u_alu (
    .op (x_op_r),
    .iw (x_iw_r),
    .a  (a_fwd),
    .d  (d_fwd),
    .ex (ex_x)
  );

  rilsbe_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .rd_idx   (ex_x.paddr[AW+1:2]),
    .wr_en    (y_mem_we),
    .wr_idx   (ex_r.paddr[AW+1:2]),
    .wr_data  (st_word),
    .rdata    (mem_word),
    .clr_busy (clr_busy)
  );

  // byte lane select, little-endian
  assign byte_sh     = {ex_r.paddr[1:0], 3'b000};
  assign ld_byte     = 8'(mem_word >> byte_sh);
  assign ld_byte_ext = {{(XLEN-8){ld_byte[7]}}, ld_byte};
  assign st_mask     = {{(XLEN-8){1'b0}}, 8'hFF} << byte_sh;
  assign st_word_b   = (mem_word & ~st_mask)
                     | ({{(XLEN-8){1'b0}}, ex_r.st_data[7:0]} << byte_sh);
  assign st_word     = ex_r.st_w ? ex_r.st_data : st_word_b;
  assign y_mem_we    = y_vld_r && (ex_r.st_w || ex_r.st_b);

  always_comb begin
    y_wr.vld  = y_vld_r && ex_r.wr;
    y_wr.idx  = ex_r.rd;
    y_wr.data = ex_r.ld_w ? mem_word : (ex_r.ld_b ? ld_byte_ext : ex_r.alu_val);
  end

  assign br_tgt = pc_r + {{(XLEN-OFFS_W-2){ex_r.offs[OFFS_W-1]}}, ex_r.offs, 2'b00};

  always_comb begin
    priority if (ex_r.fault) begin
      npc = pc_r;
    end else if (ex_r.taken) begin
      npc = br_tgt;
    end else begin
      npc = pc_r + XLEN'(4);
    end
  end

  always_comb begin
    res_nxt.next_pc      = npc;
    res_nxt.reg_written  = ex_r.wr;
    res_nxt.dest_reg     = ex_r.wr ? ex_r.rd : '0;
    res_nxt.dest_value   = ex_r.wr ? y_wr.data : '0;
    res_nxt.mem_written  = ex_r.st_w || ex_r.st_b;
    res_nxt.access_addr  = ex_r.is_mem ? ex_r.paddr : '0;
    res_nxt.branch_taken = ex_r.taken;
    res_nxt.align_fault  = ex_r.fault;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.next_pc      = res_r.next_pc;
  assign out_ch.reg_written  = res_r.reg_written;
  assign out_ch.dest_reg     = res_r.dest_reg;
  assign out_ch.dest_value   = res_r.dest_value;
  assign out_ch.mem_written  = res_r.mem_written;
  assign out_ch.access_addr  = res_r.access_addr;
  assign out_ch.branch_taken = res_r.branch_taken;
  assign out_ch.align_fault  = res_r.align_fault;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("item accepted during memory clear");

  a_pipe_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !x_vld_r && !y_vld_r)
    else $error("pipeline busy during memory clear");

  a_fault_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.align_fault |->
      !out_ch.reg_written && !out_ch.mem_written && !out_ch.branch_taken)
    else $error("faulting access changed state");

  a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    adv && y_vld_r && ex_r.fault |=> pc_r == $past(pc_r))
    else $error("pc moved on a faulting access");

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    y_wr.vld |-> y_wr.idx != '0)
    else $error("write to register zero");

endmodule

// ===== rtl/rilsbe_gpr.sv =====
module rilsbe_gpr (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic [rilsbe_pkg::GPR_AW-1:0]        rd_idx_a,
  input  logic [rilsbe_pkg::GPR_AW-1:0]        rd_idx_b,
  input  rilsbe_pkg::gpr_wr_t                  wr,
  output logic [rilsbe_pkg::XLEN-1:0]          rdata_a,
  output logic [rilsbe_pkg::XLEN-1:0]          rdata_b
);
  import rilsbe_pkg::*;

  logic [XLEN-1:0]  regs [GPR_N];
  logic [GPR_N-1:0] vld_r;
  logic [XLEN-1:0]  q_a_r, q_b_r, byp_data_r;
  logic             vld_a_r, vld_b_r, byp_a_r, byp_b_r;

  always_ff @(posedge clk) begin
    if (en && wr.vld) begin
      regs[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r      <= regs[rd_idx_a];
      q_b_r      <= regs[rd_idx_b];
      byp_data_r <= wr.data;
    end
  end

  // valid bits stand in for the reset clear; a same-edge write is bypassed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else if (en) begin
      if (wr.vld) begin
        vld_r[wr.idx] <= 1'b1;
      end
      vld_a_r <= vld_r[rd_idx_a];
      vld_b_r <= vld_r[rd_idx_b];
      byp_a_r <= wr.vld && (wr.idx == rd_idx_a);
      byp_b_r <= wr.vld && (wr.idx == rd_idx_b);
    end
  end

  assign rdata_a = byp_a_r ? byp_data_r : (vld_a_r ? q_a_r : '0);
  assign rdata_b = byp_b_r ? byp_data_r : (vld_b_r ? q_b_r : '0);

endmodule

// ===== rtl/rilsbe_dmem.sv =====
module rilsbe_dmem #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [$clog2(MEM_WORDS)-1:0]  rd_idx,
  input  logic                          wr_en,
  input  logic [$clog2(MEM_WORDS)-1:0]  wr_idx,
  input  logic [rilsbe_pkg::XLEN-1:0]   wr_data,
  output logic [rilsbe_pkg::XLEN-1:0]   rdata,
  output logic                          clr_busy
);
  import rilsbe_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [XLEN-1:0] q_r, byp_data_r;
  logic            byp_r;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_idx_r;

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (en && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r        <= mem[rd_idx];
      byp_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r      <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      if (en) begin
        byp_r <= wr_en && (wr_idx == rd_idx);
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(MEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign rdata    = byp_r ? byp_data_r : q_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== rtl/rilsbe_alu.sv =====
module rilsbe_alu (
  input  rilsbe_pkg::op_t               op,
  input  logic [rilsbe_pkg::XLEN-1:0]   iw,
  input  logic [rilsbe_pkg::XLEN-1:0]   a,
  input  logic [rilsbe_pkg::XLEN-1:0]   d,
  output rilsbe_pkg::ex_t               ex
);
  import rilsbe_pkg::*;

  logic [GPR_AW-1:0] rd;
  logic [IMM_W-1:0]  imm;
  logic [XLEN-1:0]   uimm, simm, sum;
  logic              wr;
  logic              misal;

  assign rd    = iw[4:0];
  assign imm   = iw[21:10];
  assign uimm  = {{(XLEN-IMM_W){1'b0}}, imm};
  assign simm  = sext12(imm);
  assign sum   = a + simm;
  assign misal = (sum[1:0] != 2'b00);

  always_comb begin
    ex         = '0;
    wr         = 1'b0;
    ex.rd      = rd;
    ex.paddr   = sum[PA_W-1:0];
    ex.st_data = d;
    ex.offs    = iw[23:10];
    unique case (op)
      OP_ORI:   begin wr = 1'b1; ex.alu_val = a | uimm; end
      OP_ANDI:  begin wr = 1'b1; ex.alu_val = a & uimm; end
      OP_XORI:  begin wr = 1'b1; ex.alu_val = a ^ uimm; end
      OP_ADDIW: begin wr = 1'b1; ex.alu_val = sum; end
      OP_SLTUI: begin wr = 1'b1; ex.alu_val = {{(XLEN-1){1'b0}}, a < simm}; end
      OP_LDW: begin
        ex.is_mem = 1'b1;
        ex.fault  = misal;
        ex.ld_w   = !misal;
        wr        = !misal;
      end
      OP_STW: begin
        ex.is_mem = 1'b1;
        ex.fault  = misal;
        ex.st_w   = !misal;
      end
      OP_LDB: begin
        ex.is_mem = 1'b1;
        ex.ld_b   = 1'b1;
        wr        = 1'b1;
      end
      OP_STB: begin
        ex.is_mem = 1'b1;
        ex.st_b   = 1'b1;
      end
      OP_BEQ:  ex.taken = (a == d);
      OP_BNE:  ex.taken = (a != d);
      OP_BGEU: ex.taken = (a >= d);
      default: ;
    endcase
    // writes to register zero are dropped
    ex.wr = wr && (rd != '0);
  end

endmodule
